### src/mvhp_pkg.sv
// Shared types, start codes and helpers of the video header parser.
package mvhp_pkg;

	// Start code values (byte after the 00 00 01 prefix)
	localparam logic [7:0] CODE_PICTURE    = 8'h00;
	localparam logic [7:0] CODE_SEQUENCE   = 8'hb3;
	localparam logic [7:0] CODE_EXTENSION  = 8'hb5;
	localparam logic [7:0] CODE_GOP        = 8'hb8;
	localparam logic [7:0] CODE_SLICE_LAST = 8'haf;

	// Prefix bytes
	localparam logic [7:0] PREFIX_ZERO = 8'h00;
	localparam logic [7:0] PREFIX_ONE  = 8'h01;

	// Extension identifiers
	localparam logic [3:0] EXT_SEQUENCE       = 4'h1;
	localparam logic [3:0] EXT_DISPLAY        = 4'h2;
	localparam logic [3:0] EXT_PICTURE_CODING = 4'h8;

	localparam logic [7:0] COLOUR_UNSPECIFIED = 8'd2;
	localparam logic [2:0] PIC_TYPE_I         = 3'd1;
	localparam logic [2:0] PIC_TYPE_NONE      = 3'd0;

	// Repeat codes
	localparam logic [2:0] REPEAT_NONE   = 3'd0;
	localparam logic [2:0] REPEAT_NORMAL = 3'd1;
	localparam logic [2:0] REPEAT_TWO    = 3'd2;
	localparam logic [2:0] REPEAT_THREE  = 3'd3;
	localparam logic [2:0] REPEAT_FIVE   = 3'd5;

	typedef enum logic [1:0] {
		ORDER_UNKNOWN      = 2'd0,
		ORDER_PROGRESSIVE  = 2'd1,
		ORDER_TOP_FIRST    = 2'd2,
		ORDER_BOTTOM_FIRST = 2'd3
	} scan_parity_t;

	// Payload bytes each header needs before it is evaluated
	localparam logic [2:0] LEFT_PICTURE  = 3'd2;
	localparam logic [2:0] LEFT_SEQUENCE = 3'd3;
	localparam logic [2:0] LEFT_EXT_ID   = 3'd1;
	localparam logic [2:0] LEFT_SEQ_EXT  = 3'd3;
	localparam logic [2:0] LEFT_DISPLAY  = 3'd4;
	localparam logic [2:0] LEFT_PIC_EXT  = 3'd5;
	localparam logic [2:0] LEFT_GOP      = 3'd4;

	// Window geometry: code byte up to five bytes back, five payload bytes
	localparam int HIST_DEPTH  = 6;
	localparam int MARK_DEPTH  = 5;
	localparam int PAYLOAD_LEN = 5;
	localparam logic [2:0] SCAN_MIN_BYTES = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  picture_type;
		logic        intra_entry;
		logic        closed_gop_mark;
		logic [13:0] frame_width;
		logic [13:0] frame_height;
		logic [2:0]  repeat_count;
		logic [1:0]  scan_parity;
		logic        progressive_frame_mark;
		logic [7:0]  colour_space;
	} out_item_t;

	typedef struct packed {
		logic seq;
		logic gop;
		logic closed;
		logic stopped;
	} buf_flags_t;

	typedef struct packed {
		logic [2:0] pic_type;
		logic       key;
		logic       closed_mark;
		logic [2:0] rep_count;
		logic [1:0] order;
		logic       frame_mark;
		logic [7:0] colour;
	} acc_t;

	typedef struct packed {
		logic [13:0] width;
		logic [13:0] height;
		logic        prog_seq;
	} stored_t;

	// One code to evaluate this cycle, with its payload window
	typedef struct packed {
		logic                        valid;
		logic [7:0]                  code;
		logic [PAYLOAD_LEN-1:0][7:0] payload;
		logic [2:0]                  left;
	} eval_req_t;

	function automatic acc_t acc_clear();
		acc_t a;
		a.pic_type    = PIC_TYPE_NONE;
		a.key         = 1'b0;
		a.closed_mark = 1'b0;
		a.rep_count   = REPEAT_NONE;
		a.order       = ORDER_UNKNOWN;
		a.frame_mark  = 1'b0;
		a.colour      = COLOUR_UNSPECIFIED;
		return a;
	endfunction

endpackage

### src/mpeg_video_header_parser_unit.sv
// Top level of the video start code header parser: one buffer byte per item.
// Path: the input register takes each byte; the result register loads when a last byte leaves it.
// Throughput: one byte per cycle unless a last byte waits on a full result register; one input and one result register.
// A full result register holds only the last byte of the next buffer, other bytes keep moving.
// Reset (arst_n low, asynchronous) clears window, flags, stored size and both valid bits.
module mpeg_video_header_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mvhp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mvhp_pkg::out_item_t out_data
);
	import mvhp_pkg::*;

	// Input register
	logic      valid_s1;
	in_item_t  item_s1;

	// Result register
	logic      out_valid_q;
	out_item_t out_data_q;

	// Parser state
	buf_flags_t flags_q;
	buf_flags_t flags_n;
	acc_t       acc_q;
	acc_t       acc_n;
	stored_t    stored_q;
	stored_t    stored_n;
	eval_req_t  req;
	logic       step;

	// Advance the registered byte unless it is a last byte facing a full result register
	assign step     = valid_s1 && (!item_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	// Window and code selection
	mvhp_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.stopped_next(flags_n.stopped),
		.req         (req)
	);

	// Header decode of the selected code
	mvhp_hdr u_hdr (
		.req     (req),
		.flags   (flags_q),
		.stored  (stored_q),
		.acc     (acc_q),
		.flags_n (flags_n),
		.stored_n(stored_n),
		.acc_n   (acc_n)
	);

	// Keep size and progressive flag across buffers; clear per-buffer state at buffer end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			flags_q  <= '0;
			acc_q    <= acc_clear();
		end else if (step) begin
			stored_q <= stored_n;
			if (item_s1.last_byte) begin
				flags_q <= '0;
				acc_q   <= acc_clear();
			end else begin
				flags_q <= flags_n;
				acc_q   <= acc_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step && item_s1.last_byte)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Load the buffer summary with the updates of the last byte folded in
	always_ff @(posedge clk) begin
		if (step && item_s1.last_byte) begin
			out_data_q.picture_type           <= acc_n.pic_type;
			out_data_q.intra_entry            <= acc_n.key;
			out_data_q.closed_gop_mark        <= acc_n.closed_mark;
			out_data_q.frame_width            <= stored_n.width;
			out_data_q.frame_height           <= stored_n.height;
			out_data_q.repeat_count           <= acc_n.rep_count;
			out_data_q.scan_parity            <= acc_n.order;
			out_data_q.progressive_frame_mark <= acc_n.frame_mark;
			out_data_q.colour_space           <= acc_n.colour;
		end
	end

	// A processed last byte always lands in the result register
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.last_byte) |=> out_valid_q)
		else $error("last byte did not produce a result");

	// Per-buffer state starts clean after every buffer end
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.last_byte) |=>
			(flags_q == '0) && (acc_q.colour == COLOUR_UNSPECIFIED) &&
			(acc_q.pic_type == PIC_TYPE_NONE))
		else $error("buffer state not cleared after last byte");

	// Ordinary bytes never stall
	a_plain_byte_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !item_s1.last_byte) |-> (step && in_ready))
		else $error("non-final byte stalled");

	// Persistent size changes only when a byte is processed
	a_size_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(stored_q))
		else $error("stored size changed without a processed byte");

endmodule

### src/mvhp_scan.sv
// Byte window, start code detection and selection of the code to evaluate.
module mvhp_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  mvhp_pkg::in_item_t item,
	input  logic               stopped_next,
	output mvhp_pkg::eval_req_t req
);
	import mvhp_pkg::*;

	logic [7:0]            hist_q [HIST_DEPTH-1];
	logic [7:0]            hist_n [HIST_DEPTH];
	logic [MARK_DEPTH-1:0] marks_q;
	logic [2:0]            cnt_q;
	logic [2:0]            cnt_n;
	logic [2:0]            sel_k;
	logic                  found;

	always_comb begin
		hist_n[0] = item.data_byte;
		for (int i = 1; i < HIST_DEPTH; i++)
			hist_n[i] = hist_q[i-1];
		cnt_n = (cnt_q >= SCAN_MIN_BYTES) ? cnt_q : cnt_q + 3'd1;
	end

	// Oldest pending code first; codes lie at least four bytes apart
	always_comb begin
		sel_k = 3'd0;
		if (marks_q[4])
			sel_k = 3'd5;
		else if (item.last_byte) begin
			if (marks_q[3])
				sel_k = 3'd4;
			else if (marks_q[2])
				sel_k = 3'd3;
			else if (marks_q[1])
				sel_k = 3'd2;
		end
	end

	always_comb begin
		req.valid = (sel_k != 3'd0);
		req.left  = sel_k;
		case (sel_k)
			3'd5: begin
				req.code    = hist_n[5];
				req.payload = {hist_n[0], hist_n[1], hist_n[2], hist_n[3], hist_n[4]};
			end
			3'd4: begin
				req.code    = hist_n[4];
				req.payload = {8'd0, hist_n[0], hist_n[1], hist_n[2], hist_n[3]};
			end
			3'd3: begin
				req.code    = hist_n[3];
				req.payload = {16'd0, hist_n[0], hist_n[1], hist_n[2]};
			end
			3'd2: begin
				req.code    = hist_n[2];
				req.payload = {24'd0, hist_n[0], hist_n[1]};
			end
			default: begin
				req.code    = 8'd0;
				req.payload = '0;
			end
		endcase
	end

	assign found = !stopped_next && (cnt_n >= SCAN_MIN_BYTES) &&
		(hist_n[3] == PREFIX_ZERO) && (hist_n[2] == PREFIX_ZERO) &&
		(hist_n[1] == PREFIX_ONE) && !(|marks_q[2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH-1; i++)
				hist_q[i] <= 8'd0;
			marks_q <= '0;
			cnt_q   <= 3'd0;
		end else if (step) begin
			if (item.last_byte) begin
				for (int i = 0; i < HIST_DEPTH-1; i++)
					hist_q[i] <= 8'd0;
				marks_q <= '0;
				cnt_q   <= 3'd0;
			end else begin
				for (int i = 0; i < HIST_DEPTH-1; i++)
					hist_q[i] <= hist_n[i];
				marks_q <= {marks_q[MARK_DEPTH-2:0], found};
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule

### src/mvhp_hdr.sv
// Header decode: applies one start code and its payload to the parser state.
module mvhp_hdr (
	input  mvhp_pkg::eval_req_t  req,
	input  mvhp_pkg::buf_flags_t flags,
	input  mvhp_pkg::stored_t    stored,
	input  mvhp_pkg::acc_t       acc,
	output mvhp_pkg::buf_flags_t flags_n,
	output mvhp_pkg::stored_t    stored_n,
	output mvhp_pkg::acc_t       acc_n
);
	import mvhp_pkg::*;

	logic [3:0] ext_id;
	logic [2:0] pt;
	logic [1:0] hx;
	logic [1:0] vx;
	logic       tff;
	logic       rff;
	logic       pf;

	always_comb begin
		flags_n  = flags;
		stored_n = stored;
		acc_n    = acc;
		ext_id   = req.payload[0][7:4];
		pt       = req.payload[1][5:3];
		hx       = {req.payload[1][0], req.payload[2][7]};
		vx       = req.payload[2][6:5];
		tff      = req.payload[3][7];
		rff      = req.payload[3][1];
		pf       = req.payload[4][7];
		if (req.valid && !flags.stopped) begin
			if (req.code == CODE_PICTURE) begin
				if (req.left >= LEFT_PICTURE) begin
					acc_n.pic_type    = pt;
					acc_n.key         = ((pt == PIC_TYPE_I) && flags.seq) || flags.gop;
					acc_n.closed_mark = flags.closed;
				end
			end else if (req.code == CODE_SEQUENCE) begin
				if (req.left >= LEFT_SEQUENCE) begin
					flags_n.seq     = 1'b1;
					stored_n.width  = {2'b00, req.payload[0], req.payload[1][7:4]};
					stored_n.height = {2'b00, req.payload[1][3:0], req.payload[2]};
				end
			end else if (req.code == CODE_EXTENSION) begin
				if (req.left >= LEFT_EXT_ID) begin
					unique case (ext_id)
						EXT_SEQUENCE: begin
							if (req.left >= LEFT_SEQ_EXT) begin
								// add size extension only on a known base size
								if ((|stored.width) && (|stored.height)) begin
									stored_n.width  = stored.width | {hx, 12'd0};
									stored_n.height = stored.height | {vx, 12'd0};
								end
								stored_n.prog_seq = req.payload[1][3];
							end
						end
						EXT_DISPLAY: begin
							if (req.payload[0][0] && (req.left >= LEFT_DISPLAY))
								acc_n.colour = req.payload[3];
						end
						EXT_PICTURE_CODING: begin
							if (req.left >= LEFT_PIC_EXT) begin
								acc_n.rep_count = REPEAT_NORMAL;
								if (rff) begin
									if (stored.prog_seq)
										acc_n.rep_count = tff ? REPEAT_FIVE : REPEAT_THREE;
									else if (pf)
										acc_n.rep_count = REPEAT_TWO;
								end
								if (stored.prog_seq) begin
									acc_n.order      = ORDER_PROGRESSIVE;
									acc_n.frame_mark = 1'b0;
								end else begin
									acc_n.order      = tff ? ORDER_TOP_FIRST : ORDER_BOTTOM_FIRST;
									acc_n.frame_mark = pf;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end else if (req.code == CODE_GOP) begin
				if (req.left >= LEFT_GOP) begin
					flags_n.gop    = 1'b1;
					flags_n.closed = req.payload[3][6];
				end
			end else if (req.code <= CODE_SLICE_LAST) begin
				// slice code: drop everything else in this buffer
				flags_n.stopped = 1'b1;
			end
		end
	end

endmodule
